// ===== sv/flp_pkg.sv =====
// Shared types and constants for the FIR low-pass filter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package flp_pkg;

  localparam int MAX_TAPS  = 64;
  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 7;
  localparam int FRAC_W    = SAMPLE_W - 1;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = PROD_W + TAP_IDX_W + 1;

  localparam logic [CFG_W-1:0] RESET_TAPS = CFG_W'(32);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_tap;
    logic start;
    logic issue;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// ===== sv/flp_item_if.sv =====
// Input channel of the FIR filter: valid/ready handshake with load or sample payload.
// Depends on flp_pkg.
interface flp_item_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [flp_pkg::TAP_IDX_W-1:0]       tap_index;
  logic signed [flp_pkg::SAMPLE_W-1:0] value;

  modport source (output valid, output op, output tap_index, output value, input ready);
  modport sink   (input valid, input op, input tap_index, input value, output ready);
endinterface

// ===== sv/flp_result_if.sv =====
// Result channel of the FIR filter: valid/ready handshake with filtered sample payload.
// Depends on flp_pkg.
interface flp_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [flp_pkg::SAMPLE_W-1:0] filtered_sample;
  logic                                saturated;

  modport source (output valid, output filtered_sample, output saturated, input ready);
  modport sink   (input valid, input filtered_sample, input saturated, output ready);
endinterface

// ===== sv/flp_ctrl.sv =====
// Sequencing state machine of the FIR filter.
// Depends on flp_pkg and flp_item_if; drives datapath commands.
module flp_ctrl (
  input  logic             clk,
  input  logic             rst,
  flp_item_if.sink         item,
  input  flp_pkg::status_t status,
  output flp_pkg::cmd_t    cmd
);
  import flp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item.valid && item.op == OP_FILTER) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (status.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item.ready = 1'b0;
    case (state)
      S_IDLE: begin
        item.ready   = 1'b1;
        cmd.load_tap = item.valid && item.op == OP_LOAD;
        cmd.start    = item.valid && item.op == OP_FILTER;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
        cmd = '0;
      end
      S_DONE: begin
        cmd.publish = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/flp_datapath.sv =====
// Tap store, delay line, shared multiply-accumulate and output register of the FIR filter.
// Depends on flp_pkg and flp_result_if; commanded by flp_ctrl.
module flp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [flp_pkg::CFG_W-1:0]           cfg_data,
  input  logic [flp_pkg::TAP_IDX_W-1:0]       tap_index,
  input  logic signed [flp_pkg::SAMPLE_W-1:0] value,
  input  flp_pkg::cmd_t                       cmd,
  output flp_pkg::status_t                    status,
  flp_result_if.source                        result
);
  import flp_pkg::*;

  logic [CFG_W-1:0]           active_taps;
  logic [TAP_IDX_W-1:0]       last_tap;
  logic signed [SAMPLE_W-1:0] sample;
  logic [TAP_IDX_W-1:0]       idx;
  logic [TAP_IDX_W-1:0]       idx1;
  logic                       p1;
  logic                       p2;

  logic signed [SAMPLE_W-1:0] delay_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] tap_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        delay_ok;
  logic [MAX_TAPS-1:0]        tap_ok;

  logic signed [SAMPLE_W-1:0] delay_rd;
  logic signed [SAMPLE_W-1:0] tap_rd;
  logic                       delay_rd_ok;
  logic                       tap_rd_ok;
  logic signed [SAMPLE_W-1:0] shifted;
  logic signed [SAMPLE_W-1:0] coeff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_sat;
  logic [ACC_W-PROD_W+1:0]    acc_high;
  logic                       in_range;

  always_comb begin
    if (active_taps == '0) begin
      last_tap = '0;
    end else if (active_taps > CFG_W'(MAX_TAPS)) begin
      last_tap = TAP_IDX_W'(MAX_TAPS - 1);
    end else begin
      last_tap = TAP_IDX_W'(active_taps - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= RESET_TAPS;
    end else if (cfg_we) begin
      active_taps <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tap) begin
      tap_mem[tap_index] <= value;
    end
    if (cmd.issue) begin
      tap_rd   <= tap_mem[idx];
      delay_rd <= delay_mem[idx - TAP_IDX_W'(1)];
    end
    if (p1) begin
      delay_mem[idx1] <= shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_ok   <= '0;
      delay_ok <= '0;
    end else begin
      if (cmd.load_tap) begin
        tap_ok[tap_index] <= 1'b1;
      end
      if (p1) begin
        delay_ok[idx1] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      tap_rd_ok   <= tap_ok[idx];
      delay_rd_ok <= delay_ok[idx - TAP_IDX_W'(1)];
      idx1        <= idx;
    end
  end

  always_comb begin
    if (idx1 == '0) begin
      shifted = sample;
    end else if (delay_rd_ok) begin
      shifted = delay_rd;
    end else begin
      shifted = '0;
    end
    coeff = tap_rd_ok ? tap_rd : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample <= value;
      idx    <= last_tap;
    end else if (cmd.issue) begin
      idx <= idx - TAP_IDX_W'(1);
    end
    if (p1) begin
      prod <= shifted * coeff;
    end
    if (cmd.start) begin
      acc <= '0;
    end else if (p2) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= cmd.issue;
      p2 <= p1;
    end
  end

  assign acc_high = acc[ACC_W-1:PROD_W-2];
  assign in_range = (&acc_high) || !(|acc_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (in_range) begin
        out_sample <= acc[PROD_W-2:FRAC_W];
        out_sat    <= 1'b0;
      end else if (acc[ACC_W-1]) begin
        out_sample <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        out_sat    <= 1'b1;
      end else begin
        out_sample <= {1'b0, {(SAMPLE_W-1){1'b1}}};
        out_sat    <= 1'b1;
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.filtered_sample = out_sample;
  assign result.saturated       = out_sat;

  assign status.last_issue = (idx == '0);
  assign status.pipe_busy  = p1 || p2;
  assign status.out_free   = !out_valid || result.ready;

endmodule

// ===== sv/fir_lowpass_filter.sv =====
// Direct-form FIR low-pass filter over Q1.15 samples, one shared multiply-accumulate.
// Depends on flp_pkg, flp_item_if, flp_result_if, flp_ctrl and flp_datapath.
//
// Input channel (item): op selects a tap coefficient load (value written to
// tap_index, no result) or a sample push (value enters the delay line, one result).
// Result channel (result): filtered_sample is the sum of products over the
// active taps, floored by 15 bits and saturated; saturated marks clipping.
// Configuration: cfg_we/cfg_data write active_taps (0 acts as 1, above 64 as 64).
// Write it only while the block is idle.
// Sequencing: a load is written to the tap store when it is accepted. A sample
// with N active taps walks the delay line and tap store one tap per cycle
// through one read port per memory and one multiplier: it issues the N taps,
// drains the read, product and accumulate registers, then publishes to the result
// register once it is free; no new transfer is taken before the publish.
// The next item is accepted while a result waits in the output register; a
// stalled receiver holds the result, and a second finished result waits
// inside the block until the first is taken.
// Reset clears the valid flags of the delay line and tap store (both read as zero
// until written) and sets active_taps to 32; no clearing pass is needed.
module fir_lowpass_filter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [flp_pkg::CFG_W-1:0] cfg_data,
  flp_item_if.sink                  item,
  flp_result_if.source              result
);
  import flp_pkg::*;

  cmd_t    cmd;
  status_t status;

  flp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .status (status),
    .cmd    (cmd)
  );

  flp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .tap_index (item.tap_index),
    .value     (item.value),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
